// ===== rtl/core/tcc_pkg.sv =====
// Package for the touch coordinate conditioner: field widths, register
// indexes, reset values and the configuration struct that tcc_regs hands to the conditioner.
// No dependencies.
package tcc_pkg;

  localparam int COORD_W  = 12;  // raw coordinate, screen size and sensor maximum
  localparam int POS_W    = 13;  // reported position
  localparam int CNT_W    = 2;   // touch count
  localparam int TOL_W    = 8;   // jitter tolerance
  localparam int ORIENT_W = 3;
  localparam int PROD_W   = 2 * COORD_W;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 3;

  // Register indexes (byte address is four times the index)
  localparam logic [IDX_W-1:0] REG_ORIENT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH   = 3'd1;
  localparam logic [IDX_W-1:0] REG_HEIGHT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_X   = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_Y   = 3'd4;
  localparam logic [IDX_W-1:0] REG_TOL     = 3'd5;

  localparam logic [ORIENT_W-1:0] ORIENT_RST = 3'd6;
  localparam logic [COORD_W-1:0]  WIDTH_RST  = 12'd800;
  localparam logic [COORD_W-1:0]  HEIGHT_RST = 12'd480;
  localparam logic [COORD_W-1:0]  MAX_X_RST  = 12'd800;
  localparam logic [COORD_W-1:0]  MAX_Y_RST  = 12'd480;
  localparam logic [TOL_W-1:0]    TOL_RST    = 8'd5;
  localparam logic [POS_W-1:0]    PREV_X_RST = 13'd806;
  localparam logic [POS_W-1:0]    PREV_Y_RST = 13'd486;

  // Orientation bits
  localparam int ORIENT_MIRROR_X = 0;
  localparam int ORIENT_MIRROR_Y = 1;
  localparam int ORIENT_SWAP     = 2;

  typedef struct packed {
    logic [ORIENT_W-1:0] orientation;
    logic [COORD_W-1:0]  screen_width;
    logic [COORD_W-1:0]  screen_height;
    logic [COORD_W-1:0]  sensor_max_x;
    logic [COORD_W-1:0]  sensor_max_y;
    logic [TOL_W-1:0]    jitter_tolerance;
    logic                reload;     // held positions are reloaded this cycle
    logic [POS_W-1:0]    reload_x;
    logic [POS_W-1:0]    reload_y;
  } cfg_t;

endpackage

// ===== rtl/core/tcc_if.sv =====
// Valid/ready channel interfaces for the touch coordinate conditioner:
// one for raw samples and one for conditioned reports. Depends on tcc_pkg.
interface tcc_in_if;
  import tcc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CNT_W-1:0]   touch_count;
  logic [COORD_W-1:0] raw_x;
  logic [COORD_W-1:0] raw_y;
  logic               read_error;

  modport source(output valid, touch_count, raw_x, raw_y, read_error, input ready);
  modport sink(input valid, touch_count, raw_x, raw_y, read_error, output ready);
endinterface

interface tcc_out_if;
  import tcc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] touched;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic             status;

  modport source(output valid, touched, pos_x, pos_y, status, input ready);
  modport sink(input valid, touched, pos_x, pos_y, status, output ready);
endinterface

// ===== rtl/core/tcc_regs.sv =====
// APB-style configuration registers of the touch coordinate conditioner.
// Depends on tcc_pkg.
module tcc_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tcc_pkg::DATA_W-1:0]  pwdata,
  output logic [tcc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tcc_pkg::cfg_t               cfg
);
  import tcc_pkg::*;

  logic [ORIENT_W-1:0] orient_r,  orient_nxt;
  logic [COORD_W-1:0]  width_r,   width_nxt;
  logic [COORD_W-1:0]  height_r,  height_nxt;
  logic [COORD_W-1:0]  max_x_r,   max_x_nxt;
  logic [COORD_W-1:0]  max_y_r,   max_y_nxt;
  logic [TOL_W-1:0]    tol_r,     tol_nxt;
  logic                wr;
  logic [IDX_W-1:0]    idx;
  logic                reload;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[IDX_W+1:2];

  always_comb begin
    orient_nxt = orient_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    max_x_nxt  = max_x_r;
    max_y_nxt  = max_y_r;
    tol_nxt    = tol_r;
    reload     = 1'b0;
    if (wr) begin
      case (idx)
        REG_ORIENT: orient_nxt = pwdata[ORIENT_W-1:0];
        REG_WIDTH: begin
          width_nxt = pwdata[COORD_W-1:0];
          reload    = 1'b1;
        end
        REG_HEIGHT: begin
          height_nxt = pwdata[COORD_W-1:0];
          reload     = 1'b1;
        end
        REG_MAX_X: max_x_nxt = pwdata[COORD_W-1:0];
        REG_MAX_Y: max_y_nxt = pwdata[COORD_W-1:0];
        REG_TOL: begin
          tol_nxt = pwdata[TOL_W-1:0];
          reload  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r <= ORIENT_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      max_x_r  <= MAX_X_RST;
      max_y_r  <= MAX_Y_RST;
      tol_r    <= TOL_RST;
    end else begin
      orient_r <= orient_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      max_x_r  <= max_x_nxt;
      max_y_r  <= max_y_nxt;
      tol_r    <= tol_nxt;
    end
  end

  // The reload values follow the register contents being written this cycle.
  always_comb begin
    cfg.orientation      = orient_r;
    cfg.screen_width     = width_r;
    cfg.screen_height    = height_r;
    cfg.sensor_max_x     = max_x_r;
    cfg.sensor_max_y     = max_y_r;
    cfg.jitter_tolerance = tol_r;
    cfg.reload           = reload;
    cfg.reload_x         = POS_W'({1'b0, width_nxt}) + POS_W'(tol_nxt) + POS_W'(1);
    cfg.reload_y         = POS_W'({1'b0, height_nxt}) + POS_W'(tol_nxt) + POS_W'(1);
  end

  always_comb begin
    case (idx)
      REG_ORIENT: prdata = DATA_W'(orient_r);
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      REG_MAX_X:  prdata = DATA_W'(max_x_r);
      REG_MAX_Y:  prdata = DATA_W'(max_y_r);
      REG_TOL:    prdata = DATA_W'(tol_r);
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/tcc_div.sv =====
// Shared restoring divider of the touch coordinate conditioner: one quotient
// bit per cycle. Depends on tcc_pkg.
module tcc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tcc_pkg::PROD_W-1:0]   dividend,
  input  logic [tcc_pkg::COORD_W-1:0]  divisor,
  output logic                         done,
  output logic [tcc_pkg::COORD_W-1:0]  quotient
);
  import tcc_pkg::*;

  localparam int CNT_BITS = $clog2(COORD_W);

  logic                busy_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [COORD_W-1:0]  rem_r;
  logic [COORD_W-1:0]  quo_r;
  logic [COORD_W-1:0]  div_r;
  logic [COORD_W:0]    trial;
  logic [COORD_W:0]    diff;
  logic                ge;

  // The upper half of the dividend is known to be below the divisor, so the
  // quotient fits in COORD_W bits and the low half is shifted through quo_r.
  assign trial = {rem_r, quo_r[COORD_W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(COORD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[PROD_W-1:COORD_W];
      quo_r <= dividend[COORD_W-1:0];
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
      quo_r <= {quo_r[COORD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/core/touch_coordinate_conditioner.sv =====
// Touch coordinate conditioner.
// Raw samples arrive on in_chan (valid/ready); one report per sample leaves on
// out_chan (valid/ready). Registers are written over the APB-style port
// (psel, penable, pwrite, paddr, pwdata, prdata, pready); write them only
// while no sample is in flight.
// A touched sample is conditioned axis by axis: clamp and mirror, a 12x12
// multiply, then a 12-step restoring division by the sensor maximum on the
// one shared divider. A released or erroneous sample skips these steps and
// goes straight to its report. in_chan.ready is high only between samples.
// The report waits in an output register; while the receiver stalls the
// next sample is still accepted and computed, and the block then holds it
// until the output register frees.
// Reset (synchronous, rst_n low) restores the register defaults, reloads
// the held positions to 806 and 486 and clears the last touch count.
// Depends on tcc_pkg, tcc_if, tcc_regs and tcc_div.
module touch_coordinate_conditioner #(
  parameter int COORD_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tcc_in_if.sink                      in_chan,
  tcc_out_if.source                   out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tcc_pkg::DATA_W-1:0]  pwdata,
  output logic [tcc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import tcc_pkg::*;

  localparam logic [COORD_W-1:0] RAW_MASK = (COORD_BITS >= COORD_W) ?
    {COORD_W{1'b1}} : COORD_W'((32'd1 << COORD_BITS) - 32'd1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_GO   = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  cfg_t cfg;

  logic [2:0]         state_r, state_nxt;
  logic               axis_r;
  logic               err_r;
  logic               touch_r;
  logic [CNT_W-1:0]   count_r;
  logic [COORD_W-1:0] vx_r, vy_r;
  logic [COORD_W-1:0] v_r;
  logic [PROD_W-1:0]  prod_r;
  logic [COORD_W-1:0] sx_r, sy_r;
  logic [CNT_W-1:0]   last_touched_r;
  logic [POS_W-1:0]   prev_x_r, prev_y_r;
  logic               out_valid_r;
  logic [CNT_W-1:0]   touched_r;
  logic [POS_W-1:0]   pos_x_r, pos_y_r;
  logic               status_r;

  logic               in_acc;
  logic [COORD_W-1:0] mx, my;
  logic [COORD_W-1:0] cur_v, cur_max, cur_m, cur_size, clamped, cond_v;
  logic               cur_mirror;
  logic               div_start, div_done;
  logic [COORD_W-1:0] div_q;
  logic               out_free, report;
  logic [POS_W-1:0]   ax, ay, dx, dy;
  logic               moved;
  logic [POS_W-1:0]   new_x, new_y;

  tcc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (cur_m),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid & in_chan.ready;
  assign mx            = in_chan.raw_x & RAW_MASK;
  assign my            = in_chan.raw_y & RAW_MASK;

  // Per-axis clamp and mirror against the sensor maximum (zero counts as one).
  always_comb begin
    cur_v      = axis_r ? vy_r : vx_r;
    cur_max    = axis_r ? cfg.sensor_max_y : cfg.sensor_max_x;
    cur_size   = axis_r ? cfg.screen_height : cfg.screen_width;
    cur_mirror = axis_r ? cfg.orientation[ORIENT_MIRROR_Y] : cfg.orientation[ORIENT_MIRROR_X];
    cur_m      = (cur_max == '0) ? COORD_W'(1) : cur_max;
    clamped    = (cur_v >= cur_m) ? cur_m - COORD_W'(1) : cur_v;
    cond_v     = cur_mirror ? cur_m - COORD_W'(1) - clamped : clamped;
  end

  assign div_start = (state_r == ST_GO);
  assign out_free  = !out_valid_r || out_chan.ready;
  assign report    = (state_r == ST_DONE) && out_free;

  // Deadband against the held position.
  always_comb begin
    ax    = POS_W'(sx_r);
    ay    = POS_W'(sy_r);
    dx    = (ax > prev_x_r) ? ax - prev_x_r : prev_x_r - ax;
    dy    = (ay > prev_y_r) ? ay - prev_y_r : prev_y_r - ay;
    moved = touch_r && !err_r &&
            ((dx > POS_W'(cfg.jitter_tolerance)) || (dy > POS_W'(cfg.jitter_tolerance)));
    new_x = moved ? ax : prev_x_r;
    new_y = moved ? ay : prev_y_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_chan.read_error || in_chan.touch_count == '0) ? ST_DONE : ST_PREP;
        end
      end
      ST_PREP: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_GO;
      ST_GO:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = axis_r ? ST_DONE : ST_PREP;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      last_touched_r <= '0;
      prev_x_r       <= PREV_X_RST;
      prev_y_r       <= PREV_Y_RST;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg.reload) begin
        prev_x_r <= cfg.reload_x;
        prev_y_r <= cfg.reload_y;
      end else if (report) begin
        prev_x_r <= new_x;
        prev_y_r <= new_y;
      end
      if (report && !err_r) begin
        last_touched_r <= touch_r ? count_r : '0;
      end
      if (report) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      err_r   <= in_chan.read_error;
      touch_r <= (in_chan.touch_count != '0);
      count_r <= in_chan.touch_count;
      axis_r  <= 1'b0;
      if (cfg.orientation[ORIENT_SWAP]) begin
        vx_r <= my;
        vy_r <= mx;
      end else begin
        vx_r <= mx;
        vy_r <= my;
      end
    end
    if (state_r == ST_PREP) begin
      v_r <= cond_v;
    end
    if (state_r == ST_MUL) begin
      prod_r <= PROD_W'(v_r) * PROD_W'(cur_size);
    end
    if (state_r == ST_DIV && div_done) begin
      if (axis_r) begin
        sy_r <= div_q;
      end else begin
        sx_r   <= div_q;
        axis_r <= 1'b1;
      end
    end
    if (report) begin
      touched_r <= err_r ? last_touched_r : (touch_r ? count_r : '0);
      status_r  <= err_r;
      pos_x_r   <= new_x;
      pos_y_r   <= new_y;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.touched = touched_r;
  assign out_chan.pos_x   = pos_x_r;
  assign out_chan.pos_y   = pos_y_r;
  assign out_chan.status  = status_r;

endmodule

// ===== verif/tcc_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the touch coordinate conditioner: follows register writes,
// predicts one report per accepted sample and compares accepted reports.
// Depends on tcc_pkg and the channel interfaces in tcc_if.
module tcc_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  tcc_in_if                          in_mon,
  tcc_out_if                         out_mon,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [tcc_pkg::ADDR_W-1:0] paddr,
  input  logic [tcc_pkg::DATA_W-1:0] pwdata,
  output int unsigned                mismatches,
  output int unsigned                reports_due
);
  import tcc_pkg::*;

  typedef struct packed {
    logic [CNT_W-1:0] touched;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             status;
  } report_t;

  logic [ORIENT_W-1:0] orient;
  logic [COORD_W-1:0]  width;
  logic [COORD_W-1:0]  height;
  logic [COORD_W-1:0]  max_x;
  logic [COORD_W-1:0]  max_y;
  logic [TOL_W-1:0]    tol;
  logic [POS_W-1:0]    held_x;
  logic [POS_W-1:0]    held_y;
  logic [CNT_W-1:0]    last_count;

  report_t     report_q[$];
  int unsigned fail_total = 0;
  int unsigned report_idx = 0;

  function automatic void reload_held();
    held_x = POS_W'(int'(width) + int'(tol) + 1);
    held_y = POS_W'(int'(height) + int'(tol) + 1);
  endfunction

  // Clamp into the sensor range, mirror, then scale to the screen size.
  function automatic logic [POS_W-1:0] scale_axis(input logic [COORD_W-1:0] v,
                                                  input logic [COORD_W-1:0] maxv,
                                                  input logic mirror,
                                                  input logic [COORD_W-1:0] size);
    logic [COORD_W-1:0] m;
    logic [COORD_W-1:0] c;
    logic [PROD_W-1:0]  prod;
    m = (maxv == '0) ? COORD_W'(1) : maxv;
    c = (v >= m) ? m - 1'b1 : v;
    if (mirror) c = m - c - 1'b1;
    prod = c * size;
    return POS_W'(prod / m);
  endfunction

  function automatic report_t condition_sample(input logic [CNT_W-1:0] count,
                                               input logic [COORD_W-1:0] rx,
                                               input logic [COORD_W-1:0] ry,
                                               input logic err);
    report_t            r;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [POS_W-1:0]   sx;
    logic [POS_W-1:0]   sy;
    int                 dx;
    int                 dy;
    r.status = 1'b0;
    if (err) begin
      r.touched = last_count;
      r.status  = 1'b1;
    end else if (count != '0) begin
      ax = orient[ORIENT_SWAP] ? ry : rx;
      ay = orient[ORIENT_SWAP] ? rx : ry;
      sx = scale_axis(ax, max_x, orient[ORIENT_MIRROR_X], width);
      sy = scale_axis(ay, max_y, orient[ORIENT_MIRROR_Y], height);
      dx = int'(sx) - int'(held_x);
      dy = int'(sy) - int'(held_y);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      // The held position only follows a move larger than the tolerance.
      if (dx > int'(tol) || dy > int'(tol)) begin
        held_x = sx;
        held_y = sy;
      end
      r.touched  = count;
      last_count = count;
    end else begin
      r.touched  = '0;
      last_count = '0;
    end
    r.pos_x = held_x;
    r.pos_y = held_y;
    return r;
  endfunction

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (!rst_n) begin
      orient     = ORIENT_RST;
      width      = WIDTH_RST;
      height     = HEIGHT_RST;
      max_x      = MAX_X_RST;
      max_y      = MAX_Y_RST;
      tol        = TOL_RST;
      last_count = '0;
      reload_held();
      report_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_ORIENT: orient = pwdata[ORIENT_W-1:0];
          REG_WIDTH: begin
            width = pwdata[COORD_W-1:0];
            reload_held();
          end
          REG_HEIGHT: begin
            height = pwdata[COORD_W-1:0];
            reload_held();
          end
          REG_MAX_X: max_x = pwdata[COORD_W-1:0];
          REG_MAX_Y: max_y = pwdata[COORD_W-1:0];
          REG_TOL: begin
            tol = pwdata[TOL_W-1:0];
            reload_held();
          end
          default: ;
        endcase
      end

      // A report can never belong to a sample accepted at the same edge,
      // so the comparison is done before the new prediction is queued.
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.touched, out_mon.pos_x, out_mon.pos_y, out_mon.status};
        if (report_q.size() == 0) begin
          if (fail_total < 10)
            $display("report %0d arrived with none expected: touched=%0d x=%0d y=%0d status=%0d",
                     report_idx, got.touched, got.pos_x, got.pos_y, got.status);
          fail_total++;
        end else begin
          want = report_q.pop_front();
          if (got.touched !== want.touched || got.pos_x !== want.pos_x ||
              got.pos_y !== want.pos_y || got.status !== want.status) begin
            if (fail_total < 10)
              $display("report %0d: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                       report_idx, want.touched, want.pos_x, want.pos_y, want.status,
                       got.touched, got.pos_x, got.pos_y, got.status);
            fail_total++;
          end
        end
        report_idx++;
      end

      if (in_mon.valid && in_mon.ready)
        report_q.push_back(condition_sample(in_mon.touch_count, in_mon.raw_x,
                                            in_mon.raw_y, in_mon.read_error));
    end
    reports_due <= report_q.size();
    mismatches  <= fail_total;
  end

endmodule

// ===== verif/tb_touch_coordinate_conditioner.sv =====
`timescale 1ns / 1ps
// Top of the touch coordinate conditioner testbench: clock, reset, register
// settings, sample stimulus with random stalls, watchdog and verdict.
// Depends on tcc_pkg, tcc_if, the block itself and tcc_checker.
module tb_touch_coordinate_conditioner;
  import tcc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 222;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int unsigned       mismatches;
  int unsigned       reports_due;

  tcc_in_if  in_chan();
  tcc_out_if out_chan();

  touch_coordinate_conditioner u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tcc_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .reports_due(reports_due)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles = 0;

  logic [ORIENT_W-1:0] cur_orient;
  logic [COORD_W-1:0]  cur_max_x;
  logic [COORD_W-1:0]  cur_max_y;
  logic [COORD_W-1:0]  last_x;
  logic [COORD_W-1:0]  last_y;

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Nothing moving on either channel or the register port for too long.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_sample(input logic [CNT_W-1:0] count, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input logic err);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.touch_count <= count;
    in_chan.raw_x       <= x;
    in_chan.raw_y       <= y;
    in_chan.read_error  <= err;
    last_x = x;
    last_y = y;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // psel stays high between back-to-back writes; the caller drops it.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [ORIENT_W-1:0] o, input logic [COORD_W-1:0] w,
                                input logic [COORD_W-1:0] h, input logic [COORD_W-1:0] mx,
                                input logic [COORD_W-1:0] my, input logic [TOL_W-1:0] t);
    write_reg(REG_ORIENT, DATA_W'(o));
    write_reg(REG_WIDTH, DATA_W'(w));
    write_reg(REG_HEIGHT, DATA_W'(h));
    write_reg(REG_MAX_X, DATA_W'(mx));
    write_reg(REG_MAX_Y, DATA_W'(my));
    write_reg(REG_TOL, DATA_W'(t));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_orient = o;
    cur_max_x  = mx;
    cur_max_y  = my;
  endtask

  // A random size or maximum between one and the given upper bound.
  function automatic logic [COORD_W-1:0] rand_size(input int unsigned hi);
    return COORD_W'($urandom_range(hi, 1));
  endfunction

  // Mostly in-range positions and small moves around the last one, so that
  // the deadband both holds and releases; the rest clamps or is arbitrary.
  function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] last,
                                                    input logic [COORD_W-1:0] maxv);
    int v;
    case ($urandom_range(9))
      0: v = $urandom_range(4095);
      1: v = $urandom_range(4095, maxv);
      2, 3, 4: begin
        v = int'(last) + int'($urandom_range(16)) - 8;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
      end
      default: v = (maxv <= 1) ? 0 : $urandom_range(maxv - 1);
    endcase
    return COORD_W'(v);
  endfunction

  initial begin
    logic [CNT_W-1:0]   count;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               err;
    int unsigned        r;

    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.touch_count <= '0;
    in_chan.raw_x       <= '0;
    in_chan.raw_y       <= '0;
    in_chan.read_error  <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    send_idle_pct = 32;
    recv_idle_pct = 87;
    cur_orient    = ORIENT_RST;
    cur_max_x     = MAX_X_RST;
    cur_max_y     = MAX_Y_RST;
    last_x        = '0;
    last_y        = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed samples under the reset settings (axes swapped, y mirrored).
    send_sample(2'd0, 12'd0, 12'd0, 1'b1);          // error before any touch
    send_sample(2'd0, 12'd0, 12'd0, 1'b0);
    send_sample(2'd1, 12'd0, 12'd0, 1'b0);
    send_sample(2'd2, 12'd4095, 12'd4095, 1'b0);    // clamped on both axes
    send_sample(2'd3, 12'd100, 12'd200, 1'b0);
    send_sample(2'd2, 12'd1234, 12'd567, 1'b1);     // report repeated
    send_sample(2'd1, 12'd101, 12'd201, 1'b0);      // within the deadband
    send_sample(2'd1, 12'd479, 12'd799, 1'b0);      // one below the maxima
    send_sample(2'd1, 12'd480, 12'd800, 1'b0);      // exactly at the maxima
    send_sample(2'd0, 12'd300, 12'd300, 1'b0);
    send_sample(2'd0, 12'd300, 12'd300, 1'b1);
    send_sample(2'd1, 12'hAAA, 12'h555, 1'b0);
    send_sample(2'd2, 12'h555, 12'hAAA, 1'b0);
    send_sample(2'd1, 12'd300, 12'd300, 1'b0);
    send_sample(2'd1, 12'd300, 12'd305, 1'b0);      // moved by the tolerance
    send_sample(2'd1, 12'd300, 12'd306, 1'b0);      // one beyond it
    send_sample(2'd3, 12'd306, 12'd306, 1'b0);
    send_sample(2'd3, 12'd0, 12'd4095, 1'b1);

    for (int p = 0; p < 9; p++) begin
      wait_drained();
      if (p < 3) begin
        send_idle_pct = 32;
        recv_idle_pct = 87;
      end else if (p < 6) begin
        send_idle_pct = 87;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: apply_settings(3'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 8'd0);
        1: apply_settings(3'd7, 12'd1, 12'd1, 12'd1, 12'd1, 8'd255);
        2: apply_settings(3'd5, 12'd320, 12'd240, 12'd0, 12'd0, 8'd3);   // zero maxima
        3: apply_settings(3'd1, 12'd4095, 12'd1, 12'd17, 12'd4095, 8'd0);
        4: apply_settings(3'd2, rand_size(4095), rand_size(4095),
                          rand_size(4095), rand_size(4095),
                          TOL_W'($urandom_range(15)));
        5: apply_settings(3'd3, rand_size(1024), rand_size(1024),
                          rand_size(4095), rand_size(4095),
                          TOL_W'($urandom_range(15)));
        6: apply_settings(3'd4, rand_size(4095), rand_size(4095),
                          rand_size(512), rand_size(512),
                          TOL_W'($urandom_range(31)));
        7: apply_settings(3'd6, rand_size(4095), rand_size(4095),
                          rand_size(4095), rand_size(4095),
                          TOL_W'($urandom_range(8)));
        default: apply_settings(ORIENT_W'($urandom_range(7)), rand_size(4095),
                                rand_size(4095), rand_size(4095),
                                rand_size(4095), TOL_W'($urandom_range(255)));
      endcase

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        err = ($urandom_range(99) < 8);
        r = $urandom_range(99);
        count = (r < 12) ? 2'd0 : (r < 20) ? 2'd3 : (r < 60) ? 2'd1 : 2'd2;
        x = pick_coord(last_x, cur_orient[ORIENT_SWAP] ? cur_max_y : cur_max_x);
        y = pick_coord(last_y, cur_orient[ORIENT_SWAP] ? cur_max_x : cur_max_y);
        send_sample(count, x, y, err);
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && reports_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
